// ===== src/lpfs_pkg.sv =====
package lpfs_pkg;

   // panel geometry
   localparam int unsigned PANEL_WIDTH_DEF = 96;
   localparam int unsigned PANEL_HEIGHT    = 16;
   localparam int unsigned SCAN_PHASES     = 4;
   localparam int unsigned PHASE_W         = 2;
   localparam int unsigned Y_W             = 4;

   // store byte value for a dark group of eight pixels (active low)
   localparam logic [7:0] DARK_BYTE = 8'hff;
   // bit of the leftmost pixel in a byte
   localparam logic [7:0] MSB_MASK  = 8'b1000_0000;

   // item kinds
   localparam logic [1:0] MODE_SET   = 2'd0;
   localparam logic [1:0] MODE_CLEAR = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   typedef struct packed {
      logic [1:0]        mode;
      logic signed [7:0] x_pos;
      logic signed [7:0] y_pos;
   } req_type;

   typedef struct packed {
      logic [7:0] shift_byte;
      logic [1:0] row_select;
      logic       last;
   } rsp_type;

endpackage

// ===== src/lpfs_ram.sv =====
module lpfs_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 192
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/led_panel_frame_store_scan_top.sv =====
// Channel   Direction  Ports                           Payload
// -------   ---------  ------------------------------  -----------------------------
// request   in         req_valid, req_stall, req_data  mode, x_pos, y_pos
// response  out        rsp_valid, rsp_stall, rsp_data  shift_byte, row_select, last
//
// Refresh tick: the item is taken, then one byte per cycle goes out while the response
// side does not stall, 48 bytes at the default width (COL_BYTES * 4); the single read port
// of the frame store sets that rate. Set pixel: a read, then a write back. Clear: one store
// write per cycle over all STORE_BYTES bytes. Out of range points and unused modes are dropped.
// After reset the same clearing pass runs before the first item.
// A stall on the response side holds the tick sequencer; the output register parts the sides.
module led_panel_frame_store_scan_top #(
   parameter int unsigned PANEL_WIDTH = lpfs_pkg::PANEL_WIDTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lpfs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lpfs_pkg::rsp_type rsp_data
);

   import lpfs_pkg::*;

   localparam int unsigned COL_BYTES   = (PANEL_WIDTH + 7) / 8;
   localparam int unsigned STORE_BYTES = COL_BYTES * PANEL_HEIGHT;
   localparam int unsigned TICK_BYTES  = STORE_BYTES / SCAN_PHASES;
   localparam int unsigned ADDR_W      = $clog2(STORE_BYTES);
   localparam int unsigned TICK_W      = ADDR_W - PHASE_W;

   // sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CLR  = 2'd1;
   localparam logic [1:0] ST_PIX  = 2'd2;
   localparam logic [1:0] ST_TICK = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  cnt_ff, cnt_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [ADDR_W-1:0]  pix_addr_ff, pix_addr_in;
   logic [7:0]         pix_mask_ff, pix_mask_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic               ram_wr_en;
   logic [ADDR_W-1:0]  ram_wr_addr;
   logic [7:0]         ram_wr_data;
   logic               ram_rd_en;
   logic [ADDR_W-1:0]  ram_rd_addr;
   logic [7:0]         ram_rd_data;

   logic               req_fire;
   logic               out_free;
   logic               x_ok;
   logic               y_ok;
   logic [7:0]         mx;
   logic [8:0]         pix_idx;
   logic [ADDR_W-1:0]  cnt_plus;
   logic               tick_last;
   logic               clr_last;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // point decode: mirror x, byte = column byte * 16 + y
   assign x_ok    = !req_data.x_pos[7] && ({1'b0, req_data.x_pos} < 9'(PANEL_WIDTH));
   assign y_ok    = !req_data.y_pos[7] && (req_data.y_pos[6:Y_W] == '0);
   assign mx      = 8'(PANEL_WIDTH - 1) - $unsigned(req_data.x_pos);
   assign pix_idx = {mx[7:3], req_data.y_pos[Y_W-1:0]};

   assign cnt_plus  = cnt_ff + 1'b1;
   assign tick_last = (cnt_ff == ADDR_W'(TICK_BYTES - 1));
   assign clr_last  = (cnt_ff == ADDR_W'(STORE_BYTES - 1));

   // sequencer around the frame store port
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      phase_in     = phase_ff;
      pix_addr_in  = pix_addr_ff;
      pix_mask_in  = pix_mask_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = cnt_ff;
      ram_wr_data  = DARK_BYTE;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = {TICK_W'(0), phase_ff};

      case (state_ff)
         ST_CLR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff;
            ram_wr_data = DARK_BYTE;
            if (clr_last) begin
               state_in = ST_IDLE;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_plus;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               case (req_data.mode)
                  MODE_SET: begin
                     if (x_ok && y_ok) begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = pix_idx[ADDR_W-1:0];
                        pix_addr_in = pix_idx[ADDR_W-1:0];
                        pix_mask_in = MSB_MASK >> mx[2:0];
                        state_in    = ST_PIX;
                     end
                  end
                  MODE_CLEAR: begin
                     cnt_in   = '0;
                     state_in = ST_CLR;
                  end
                  MODE_TICK: begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = {TICK_W'(0), phase_ff};
                     cnt_in      = '0;
                     state_in    = ST_TICK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PIX: begin
            // write back with the pixel bit cleared (lit)
            ram_wr_en   = 1'b1;
            ram_wr_addr = pix_addr_ff;
            ram_wr_data = ram_rd_data & ~pix_mask_ff;
            state_in    = ST_IDLE;
         end
         ST_TICK: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.shift_byte = ram_rd_data;
               rsp_data_in.row_select = ~phase_ff;
               rsp_data_in.last       = tick_last;
               if (tick_last) begin
                  phase_in = phase_ff + 1'b1;
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end else begin
                  // fetch the next byte while this one goes out
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = {cnt_plus[TICK_W-1:0], phase_ff};
                  cnt_in      = cnt_plus;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         cnt_ff       <= '0;
         phase_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pix_addr_ff <= pix_addr_in;
      pix_mask_ff <= pix_mask_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // frame store
   lpfs_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

`ifndef ASSERT_OFF
   // reset starts the clearing pass
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (state_ff == ST_CLR) && (cnt_ff == '0))
      else $error("clearing pass not started after reset");

   // a pixel update is one read and one write
   a_pix_short: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PIX) |=> (state_ff == ST_IDLE))
      else $error("pixel write back did not finish");

   // the final byte of a tick ends the tick and advances the phase
   a_tick_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TICK) && out_free && tick_last
      |=> (state_ff == ST_IDLE) && (phase_ff == $past(phase_ff) + 2'd1)
          && rsp_valid && rsp_data.last)
      else $error("tick did not end on its last byte");

   // the phase only moves at the end of a tick
   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !((state_ff == ST_TICK) && out_free && tick_last) |=> $stable(phase_ff))
      else $error("scan phase changed outside a tick end");
`endif

endmodule

// ===== test/led_panel_frame_store_scan_top_tb.sv =====
`timescale 1ns / 1ps

module led_panel_frame_store_scan_top_tb;
   import lpfs_pkg::*;

   // geometry at the default panel width, kept as signed ints for index math
   localparam int WIDTH        = PANEL_WIDTH_DEF;
   localparam int HEIGHT       = PANEL_HEIGHT;
   localparam int PHASES       = SCAN_PHASES;
   localparam int COL_BYTES    = (WIDTH + 7) / 8;
   localparam int STORE_BYTES  = COL_BYTES * HEIGHT;
   localparam int TICK_BYTES   = STORE_BYTES / PHASES;
   localparam int DRAIN_CYCLES = STORE_BYTES + 64;
   localparam int RANDOM_ITEMS = 300;
   localparam int HOLD_CYCLES  = 400;
   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Shadow frame store and scan phase; queues the bytes each tick must emit
   class scan_scoreboard;
      logic [7:0] frame_bytes [STORE_BYTES];
      logic [1:0] phase;
      rsp_type    expected_bytes [$];
      int errors, bytes_checked, items_seen;
      int pixels_drawn, points_dropped, clears, ticks, unused_items;

      function new();
         foreach (frame_bytes[i]) frame_bytes[i] = DARK_BYTE;
         phase = '0;
         errors = 0; bytes_checked = 0; items_seen = 0;
         pixels_drawn = 0; points_dropped = 0; clears = 0; ticks = 0; unused_items = 0;
      endfunction

      // update the shadow state for one accepted request transfer
      function void note_request(req_type item);
         int x, y, mx, idx;
         logic [1:0] row;
         rsp_type b;
         x = int'($signed(item.x_pos));
         y = int'($signed(item.y_pos));
         items_seen++;
         case (item.mode)
            MODE_SET: begin
               if (x < 0 || x >= WIDTH || y < 0 || y >= HEIGHT) begin
                  points_dropped++;
               end else begin
                  // panel is mirrored in x; lit pixel is a cleared bit
                  mx = WIDTH - 1 - x;
                  idx = (mx / 8) * HEIGHT + y;
                  frame_bytes[idx] &= ~(MSB_MASK >> (mx % 8));
                  pixels_drawn++;
               end
            end
            MODE_CLEAR: begin
               foreach (frame_bytes[i]) frame_bytes[i] = DARK_BYTE;
               clears++;
            end
            MODE_TICK: begin
               row = 2'(PHASES - 1) - phase;
               for (int i = 0; i < TICK_BYTES; i++) begin
                  b.shift_byte = frame_bytes[i * PHASES + int'(phase)];
                  b.row_select = row;
                  b.last       = (i == TICK_BYTES - 1);
                  expected_bytes.push_back(b);
               end
               phase = phase + 2'd1;
               ticks++;
            end
            default: unused_items++;
         endcase
      endfunction

      task report_mismatch(string msg);
         errors++;
         $display("ERROR at %0t ns: %s", $time, msg);
      endtask

      // compare one response transfer with the oldest expected byte
      task check_response(rsp_type got);
         rsp_type want;
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected scan byte %02h", got.shift_byte));
         end else begin
            want = expected_bytes.pop_front();
            bytes_checked++;
            if (got.shift_byte !== want.shift_byte)
               report_mismatch($sformatf("shift_byte %02h, want %02h",
                                         got.shift_byte, want.shift_byte));
            if (got.row_select !== want.row_select)
               report_mismatch($sformatf("row_select %0d, want %0d",
                                         got.row_select, want.row_select));
            if (got.last !== want.last)
               report_mismatch($sformatf("last %0b, want %0b", got.last, want.last));
         end
      endtask
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   scan_scoreboard sb = new();
   int burst_left = 0;
   bit hold_done  = 0;

   led_panel_frame_store_scan_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // monitors: sample transfers at the edge, before any driver update lands
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) sb.note_request(req_data);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   function automatic req_type make_request(logic [1:0] mode, int x, int y);
      req_type r;
      r.mode  = mode;
      r.x_pos = x[7:0];
      r.y_pos = y[7:0];
      return r;
   endfunction

   // offer one item; bursts of random length separated by random gaps
   task send_request(req_type item);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      burst_left--;
   endtask

   // corners, range edges, ignored items and one tick per phase
   task run_directed();
      send_request(make_request(MODE_SET, 0, 0));
      send_request(make_request(MODE_SET, WIDTH - 1, HEIGHT - 1));
      send_request(make_request(MODE_SET, WIDTH - 1, 0));
      send_request(make_request(MODE_SET, 0, HEIGHT - 1));
      send_request(make_request(MODE_SET, 7, 3));
      send_request(make_request(MODE_SET, 8, 3));
      // off-panel points change nothing
      send_request(make_request(MODE_SET, -1, 5));
      send_request(make_request(MODE_SET, WIDTH, 5));
      send_request(make_request(MODE_SET, 5, -1));
      send_request(make_request(MODE_SET, 5, HEIGHT));
      send_request(make_request(MODE_SET, -128, -128));
      send_request(make_request(MODE_SET, 127, 127));
      send_request(make_request(MODE_UNUSED, 42, 9));
      repeat (PHASES) send_request(make_request(MODE_TICK, -1, -1));
      // clear ignores its coordinates
      send_request(make_request(MODE_CLEAR, 3, 3));
      send_request(make_request(MODE_TICK, 0, 0));
      send_request(make_request(MODE_SET, 50, 6));
      send_request(make_request(MODE_SET, 51, 7));
      send_request(make_request(MODE_TICK, 127, -128));
      send_request(make_request(MODE_TICK, 0, 0));
   endtask

   // mostly on-panel drawing between ticks, with clears and noise mixed in
   task run_random();
      int done_items, pick;
      done_items = 0;
      while (done_items < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            send_request(make_request(MODE_SET, $urandom_range(0, WIDTH - 1),
                                      $urandom_range(0, HEIGHT - 1)));
         end else if (pick < 65) begin
            send_request(make_request(MODE_SET, $urandom_range(0, 255),
                                      $urandom_range(0, 255)));
         end else if (pick < 68) begin
            send_request(make_request(MODE_CLEAR, $urandom_range(0, 255),
                                      $urandom_range(0, 255)));
         end else if (pick < 71) begin
            send_request(make_request(MODE_UNUSED, $urandom_range(0, 255),
                                      $urandom_range(0, 255)));
            continue;
         end else begin
            send_request(make_request(MODE_TICK, $urandom_range(0, 255),
                                      $urandom_range(0, 255)));
         end
         done_items++;
      end
   endtask

   // response side: stretches of differing stall styles, one long hold-off
   initial begin
      int style, span, n;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (!hold_done && sb.bytes_checked >= 200) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done = 1;
         end
         style = $urandom_range(0, 3);
         span  = $urandom_range(16, 96);
         n = 0;
         repeat (span) begin
            case (style)
               0: rsp_stall <= 1'b0;
               1: rsp_stall <= ($urandom_range(0, 1) == 1);
               2: rsp_stall <= (n % 4 == 3);
               default: rsp_stall <= ($urandom_range(0, 9) < 7);
            endcase
            n++;
            @(posedge clock);
         end
      end
   end

   // main sequence
   initial begin
      int guard;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      rsp_stall <= 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      run_directed();
      run_random();
      req_valid <= 1'b0;

      guard = 0;
      while (sb.expected_bytes.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.expected_bytes.size() != 0)
         sb.report_mismatch($sformatf("%0d scan bytes never arrived",
                                      sb.expected_bytes.size()));

      $display("Run: %0d items, %0d pixels drawn, %0d off-panel, %0d clears, %0d unused",
               sb.items_seen, sb.pixels_drawn, sb.points_dropped, sb.clears,
               sb.unused_items);
      $display("Run: %0d refresh ticks, %0d scan bytes compared, %0d errors",
               sb.ticks, sb.bytes_checked, sb.errors);
      if (sb.errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
